>>> hdl/sfha_pkg.sv
// shared types, constants and helper functions of the segregated-fit heap allocator
`default_nettype none
package sfha_pkg;

    localparam int unsigned HEAP_BYTES_DEF  = 65536;
    localparam int unsigned CLASS_COUNT_DEF = 16;
    localparam int unsigned SMALLEST_BLOCK  = 32;
    localparam int unsigned HEADER_BYTES    = 8;
    localparam int unsigned WORD_BYTES      = 8;
    localparam int unsigned CLASS_SHIFT     = 5;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [31:0] HDR_FREE  = 32'h1;
    localparam logic [31:0] HDR_PREV  = 32'h2;
    localparam logic [31:0] SIZE_MASK = ~32'h3;

    // one memory access per cycle, byte offset, read data comes back in the next cycle
    typedef struct packed {
        logic        we;
        logic [31:0] off;
        logic [31:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
        logic [16:0] used;
        logic [16:0] spare;
    } t_result;

    // size class: floor(log2 s) - 5, clamped to the list range
    function automatic logic [4:0] class_of(input logic [31:0] s, input int unsigned cnt);
        logic [4:0] bits;
        logic [4:0] c;
        bits = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (s[i]) begin
                bits = 5'(i);
            end
        end
        c = (bits > 5'(CLASS_SHIFT)) ? bits - 5'(CLASS_SHIFT) : 5'd0;
        if (32'(c) >= cnt) begin
            c = 5'(cnt - 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hdl/sfha_heap_ram.sv
// heap word memory, one access per cycle, registered read data
`default_nettype none
module sfha_heap_ram #(
    parameter int unsigned AW = 13
) (
    input  wire logic              i_clk,
    input  wire sfha_pkg::t_mem_req i_req,
    output logic [31:0]            o_rdata
);
    logic [31:0] r_mem [2**AW];
    logic [AW-1:0] w_idx;

    // word index wraps modulo the heap
    assign w_idx = i_req.off[3 +: AW];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[w_idx] <= i_req.wdata;
        end
        o_rdata <= r_mem[w_idx];
    end
endmodule
`default_nettype wire

>>> hdl/sfha_ctrl.sv
// request sequencer: header, footer and link walks, list heads and counters
`default_nettype none
module sfha_ctrl #(
    parameter int unsigned HEAP_BYTES  = sfha_pkg::HEAP_BYTES_DEF,
    parameter int unsigned CLASS_COUNT = sfha_pkg::CLASS_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_action,
    input  wire logic [15:0]        i_size,
    input  wire logic [15:0]        i_addr,
    output logic                    o_ready,
    input  wire logic               i_out_free,
    output logic                    o_done,
    output sfha_pkg::t_result       o_res,
    output sfha_pkg::t_mem_req      o_mem,
    input  wire logic [31:0]        i_rdata
);
    localparam int unsigned HW = HEAP_BYTES / sfha_pkg::WORD_BYTES;
    localparam int unsigned AW = $clog2(HW);
    localparam int unsigned CW = $clog2(CLASS_COUNT);
    localparam logic [31:0] SPAN = 32'(HEAP_BYTES);
    localparam logic [16:0] SPAN17 = 17'(HEAP_BYTES);
    localparam logic [CW-1:0] INIT_CLS = CW'(sfha_pkg::class_of(SPAN, CLASS_COUNT));
    localparam logic [31:0] SMB = 32'(sfha_pkg::SMALLEST_BLOCK);
    localparam logic [31:0] HB  = 32'(sfha_pkg::HEADER_BYTES);

    localparam logic [5:0] S_CLR = 6'd0,  S_IDLE = 6'd1,  S_AC = 6'd2,   S_AK = 6'd3;
    localparam logic [5:0] S_AH = 6'd4,   S_AH2 = 6'd5,   S_AS = 6'd6,   S_AS1 = 6'd7;
    localparam logic [5:0] S_AS2 = 6'd8,  S_AS3 = 6'd9,   S_AS4 = 6'd10, S_AS5 = 6'd11;
    localparam logic [5:0] S_AS6 = 6'd12, S_AC0 = 6'd13,  S_AC1 = 6'd14, S_AF = 6'd15;
    localparam logic [5:0] S_FR0 = 6'd16, S_FR1 = 6'd17,  S_FR2 = 6'd18, S_FR3 = 6'd19;
    localparam logic [5:0] S_FR4 = 6'd20, S_FR5 = 6'd21,  S_FR6 = 6'd22, S_PV0 = 6'd23;
    localparam logic [5:0] S_PV1 = 6'd24, S_PV2 = 6'd25,  S_PV3 = 6'd26, S_PV4 = 6'd27;
    localparam logic [5:0] S_PV5 = 6'd28, S_FTG = 6'd29,  S_FN0 = 6'd30, S_FN1 = 6'd31;
    localparam logic [5:0] S_INS = 6'd32, S_FD = 6'd33,   S_DONE = 6'd34;
    localparam logic [5:0] S_RM0 = 6'd35, S_RM1 = 6'd36,  S_RM2 = 6'd37, S_RM3 = 6'd38;
    localparam logic [5:0] S_RM4 = 6'd39, S_IN0 = 6'd40,  S_IN1 = 6'd41, S_IN2 = 6'd42;
    localparam logic [5:0] S_IN3 = 6'd43, S_SP0 = 6'd44,  S_SP1 = 6'd45, S_FT0 = 6'd46;
    localparam logic [5:0] S_FT1 = 6'd47;

    logic [5:0]  r_state, n_state, r_ret, n_ret;
    logic [AW-1:0] r_clr, n_clr;
    logic [31:0] r_need, n_need, r_b, n_b, r_s, n_s, r_n, n_n, r_tgt, n_tgt;
    logic [31:0] r_tmp, n_tmp, r_pb, n_pb;
    logic [15:0] r_nx, n_nx, r_pv, n_pv, r_p, n_p, r_head, n_head;
    logic        r_on, n_on;
    logic [CW-1:0] r_cls, n_cls, r_cls2, n_cls2;
    logic [15:0] r_heads [CLASS_COUNT];
    logic [15:0] w_head_rd, w_head_wd;
    logic        w_head_we;
    logic [CLASS_COUNT-1:0] r_map, n_map;
    logic [16:0] r_used, n_used, r_spare, n_spare;
    sfha_pkg::t_result r_res, n_res;
    logic [31:0] w_sz;
    logic [CW-1:0] w_k;
    logic        w_found;
    logic [5:0]  w_c6;

    assign w_head_rd = r_heads[r_cls2];
    assign w_sz      = i_rdata & sfha_pkg::SIZE_MASK;
    assign o_ready   = (r_state == S_IDLE);
    // carries the current counters while the result is handed over
    assign o_res     = n_res;

    // lowest non-empty list at or above the search class
    always_comb begin
        w_k = '0;
        w_found = 1'b0;
        for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
            if (r_map[i] && (CW'(i) >= r_cls)) begin
                w_k = CW'(i);
                w_found = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_clr = r_clr;
        n_need = r_need; n_b = r_b; n_s = r_s; n_n = r_n; n_tgt = r_tgt;
        n_tmp = r_tmp; n_pb = r_pb; n_nx = r_nx; n_pv = r_pv; n_p = r_p;
        n_head = r_head; n_on = r_on; n_cls = r_cls; n_cls2 = r_cls2;
        n_map = r_map; n_used = r_used; n_spare = r_spare; n_res = r_res;
        w_head_we = 1'b0; w_head_wd = '0;
        o_mem = '0; o_done = 1'b0;
        w_c6 = '0;
        unique case (r_state)
            S_CLR: begin
                o_mem.we = 1'b1;
                o_mem.off = {{(29-AW){1'b0}}, r_clr, 3'b000};
                if (r_clr == '0) begin
                    o_mem.wdata = SPAN | sfha_pkg::HDR_FREE;
                end else if (r_clr == AW'(HW - 1)) begin
                    o_mem.wdata = SPAN;
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(HW - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_res.addr = '0;
                    if (!i_action) begin
                        n_need = ((HB + 32'((i_size < 16'd16) ? 16'd16 : i_size) + 32'd7)
                                  & ~32'd7);
                        if (n_need < SMB) begin
                            n_need = SMB;
                        end
                        if (i_size == '0) begin
                            n_res.status = sfha_pkg::ST_IGNORED;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_AC;
                        end
                    end else begin
                        n_b = 32'(i_addr) - HB;
                        if (i_addr == '0 || i_addr[2:0] != 3'd0 || (n_b + SMB > SPAN)) begin
                            n_res.status = sfha_pkg::ST_IGNORED;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_FR0;
                        end
                    end
                end
            end
            // allocate
            S_AC: begin
                w_c6 = 6'(sfha_pkg::class_of(r_need, CLASS_COUNT))
                     + 6'(((r_need & (r_need - 32'd1)) != '0) ? 1 : 0);
                if (32'(w_c6) >= CLASS_COUNT) begin
                    w_c6 = 6'(CLASS_COUNT - 1);
                end
                n_cls = CW'(w_c6);
                n_state = S_AK;
            end
            S_AK: begin
                n_cls2 = w_k;
                if (w_found) begin
                    n_state = S_AH;
                end else begin
                    n_res.status = sfha_pkg::ST_NOMEM;
                    n_state = S_DONE;
                end
            end
            S_AH: begin
                n_b = 32'(w_head_rd) - HB;
                o_mem.off = n_b;
                if (w_head_rd == '0) begin
                    n_res.status = sfha_pkg::ST_NOMEM;
                    n_state = S_DONE;
                end else begin
                    n_state = S_AH2;
                end
            end
            S_AH2: begin
                n_s = w_sz;
                if (w_sz < r_need) begin
                    n_res.status = sfha_pkg::ST_NOMEM;
                    n_state = S_DONE;
                end else begin
                    n_tgt = r_b; n_ret = S_AS; n_state = S_RM0;
                end
            end
            S_AS: begin
                if (r_s - r_need >= SMB) begin
                    n_n = r_b + r_need;
                    n_s = r_s - r_need;
                    o_mem.off = r_b;
                    n_state = S_AS1;
                end else begin
                    n_state = S_AC0;
                end
            end
            S_AS1: begin
                o_mem.we = 1'b1; o_mem.off = r_b;
                o_mem.wdata = r_need | (i_rdata & 32'h3);
                n_state = S_AS2;
            end
            S_AS2: begin
                o_mem.we = 1'b1; o_mem.off = r_n;
                o_mem.wdata = r_s | sfha_pkg::HDR_FREE;
                n_state = S_AS3;
            end
            S_AS3: begin
                o_mem.we = 1'b1; o_mem.off = r_n + 32'd8;
                n_state = S_AS4;
            end
            S_AS4: begin
                o_mem.we = 1'b1; o_mem.off = r_n + 32'd16;
                n_tgt = r_n; n_ret = S_AS5; n_state = S_FT0;
            end
            S_AS5: begin
                n_tgt = r_n; n_ret = S_AS6; n_state = S_IN0;
            end
            S_AS6: begin
                if (r_n + r_s < SPAN) begin
                    n_tgt = r_n + r_s; n_on = 1'b1; n_ret = S_AC0; n_state = S_SP0;
                end else begin
                    n_state = S_AC0;
                end
            end
            S_AC0: begin
                o_mem.off = r_b;
                n_state = S_AC1;
            end
            S_AC1: begin
                o_mem.we = 1'b1; o_mem.off = r_b;
                o_mem.wdata = i_rdata & ~sfha_pkg::HDR_FREE;
                n_s = w_sz;
                if (r_b + w_sz < SPAN) begin
                    n_tgt = r_b + w_sz; n_on = 1'b0; n_ret = S_AF; n_state = S_SP0;
                end else begin
                    n_state = S_AF;
                end
            end
            S_AF: begin
                n_used = r_used + r_s[16:0];
                n_spare = r_spare - r_s[16:0];
                n_res.status = sfha_pkg::ST_DONE;
                n_res.addr = 16'(r_b + HB);
                n_state = S_DONE;
            end
            // free
            S_FR0: begin
                o_mem.off = r_b;
                n_state = S_FR1;
            end
            S_FR1: begin
                if (i_rdata[0] || w_sz < SMB || (r_b + w_sz > SPAN)) begin
                    n_res.status = sfha_pkg::ST_IGNORED;
                    n_state = S_DONE;
                end else begin
                    n_used = r_used - w_sz[16:0];
                    n_spare = r_spare + w_sz[16:0];
                    o_mem.we = 1'b1; o_mem.off = r_b;
                    o_mem.wdata = i_rdata | sfha_pkg::HDR_FREE;
                    n_n = r_b + w_sz;
                    n_state = S_FR2;
                end
            end
            S_FR2: begin
                o_mem.off = r_n;
                n_state = (r_n < SPAN) ? S_FR3 : S_PV0;
            end
            S_FR3: begin
                if (i_rdata[0]) begin
                    n_tgt = r_n; n_ret = S_FR4; n_state = S_RM0;
                end else begin
                    n_state = S_PV0;
                end
            end
            S_FR4: begin
                o_mem.off = r_n;
                n_state = S_FR5;
            end
            S_FR5: begin
                n_tmp = w_sz;
                o_mem.off = r_b;
                n_state = S_FR6;
            end
            S_FR6: begin
                o_mem.we = 1'b1; o_mem.off = r_b;
                o_mem.wdata = (w_sz + r_tmp) | (i_rdata & 32'h3);
                n_state = S_PV0;
            end
            S_PV0: begin
                o_mem.off = r_b;
                n_state = S_PV1;
            end
            S_PV1: begin
                o_mem.off = r_b - 32'd8;
                n_state = i_rdata[1] ? S_PV2 : S_FTG;
            end
            S_PV2: begin
                if (i_rdata >= SMB && i_rdata <= r_b) begin
                    n_pb = r_b - i_rdata;
                    n_tgt = n_pb; n_ret = S_PV3; n_state = S_RM0;
                end else begin
                    n_state = S_FTG;
                end
            end
            S_PV3: begin
                o_mem.off = r_b;
                n_state = S_PV4;
            end
            S_PV4: begin
                n_tmp = w_sz;
                o_mem.off = r_pb;
                n_state = S_PV5;
            end
            S_PV5: begin
                o_mem.we = 1'b1; o_mem.off = r_pb;
                o_mem.wdata = (w_sz + r_tmp) | (i_rdata & 32'h3);
                n_b = r_pb;
                n_state = S_FTG;
            end
            S_FTG: begin
                n_tgt = r_b; n_ret = S_FN0; n_state = S_FT0;
            end
            S_FN0: begin
                o_mem.off = r_b;
                n_state = S_FN1;
            end
            S_FN1: begin
                if (r_b + w_sz < SPAN) begin
                    n_tgt = r_b + w_sz; n_on = 1'b1; n_ret = S_INS; n_state = S_SP0;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                n_tgt = r_b; n_ret = S_FD; n_state = S_IN0;
            end
            S_FD: begin
                n_res.status = sfha_pkg::ST_DONE;
                n_res.addr = '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_res.used = r_used;
                n_res.spare = r_spare;
                if (i_out_free) begin
                    o_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            // unlink a free block
            S_RM0: begin
                o_mem.off = r_tgt;
                n_state = S_RM1;
            end
            S_RM1: begin
                n_cls2 = CW'(sfha_pkg::class_of(w_sz, CLASS_COUNT));
                o_mem.off = r_tgt + 32'd8;
                n_state = S_RM2;
            end
            S_RM2: begin
                n_nx = i_rdata[15:0];
                o_mem.off = r_tgt + 32'd16;
                n_state = S_RM3;
            end
            S_RM3: begin
                n_pv = i_rdata[15:0];
                if (n_pv != '0) begin
                    o_mem.we = 1'b1; o_mem.off = 32'(n_pv); o_mem.wdata = 32'(r_nx);
                end else begin
                    w_head_we = 1'b1; w_head_wd = r_nx;
                end
                n_state = S_RM4;
            end
            S_RM4: begin
                if (r_nx != '0) begin
                    o_mem.we = 1'b1; o_mem.off = 32'(r_nx) + 32'd8; o_mem.wdata = 32'(r_pv);
                end
                if (w_head_rd == '0) begin
                    n_map[r_cls2] = 1'b0;
                end
                n_state = r_ret;
            end
            // push a free block on its list head
            S_IN0: begin
                o_mem.off = r_tgt;
                n_state = S_IN1;
            end
            S_IN1: begin
                n_cls2 = CW'(sfha_pkg::class_of(w_sz, CLASS_COUNT));
                n_p = 16'(r_tgt + HB);
                o_mem.we = 1'b1; o_mem.off = 32'(n_p) + 32'd8;
                n_state = S_IN2;
            end
            S_IN2: begin
                n_head = w_head_rd;
                o_mem.we = 1'b1; o_mem.off = 32'(r_p); o_mem.wdata = 32'(w_head_rd);
                n_state = S_IN3;
            end
            S_IN3: begin
                if (r_head != '0) begin
                    o_mem.we = 1'b1; o_mem.off = 32'(r_head) + 32'd8; o_mem.wdata = 32'(r_p);
                end
                w_head_we = 1'b1; w_head_wd = r_p;
                n_map[r_cls2] = 1'b1;
                n_state = r_ret;
            end
            // set or clear the previous-free flag
            S_SP0: begin
                o_mem.off = r_tgt;
                n_state = S_SP1;
            end
            S_SP1: begin
                o_mem.we = 1'b1; o_mem.off = r_tgt;
                o_mem.wdata = r_on ? (i_rdata | sfha_pkg::HDR_PREV)
                                   : (i_rdata & ~sfha_pkg::HDR_PREV);
                n_state = r_ret;
            end
            // write the footer from the header size
            S_FT0: begin
                o_mem.off = r_tgt;
                n_state = S_FT1;
            end
            S_FT1: begin
                o_mem.we = 1'b1; o_mem.off = r_tgt + w_sz - 32'd8; o_mem.wdata = w_sz;
                n_state = r_ret;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret <= S_IDLE;
            r_clr <= '0;
            r_map <= CLASS_COUNT'(1) << INIT_CLS;
            r_used <= '0;
            r_spare <= SPAN17;
            for (int i = 0; i < CLASS_COUNT; i++) begin
                r_heads[i] <= (i == int'(INIT_CLS)) ? 16'(HB) : 16'd0;
            end
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_clr <= n_clr;
            r_map <= n_map;
            r_used <= n_used;
            r_spare <= n_spare;
            if (w_head_we) begin
                r_heads[r_cls2] <= w_head_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need <= n_need; r_b <= n_b; r_s <= n_s; r_n <= n_n; r_tgt <= n_tgt;
        r_tmp <= n_tmp; r_pb <= n_pb; r_nx <= n_nx; r_pv <= n_pv; r_p <= n_p;
        r_head <= n_head; r_on <= n_on; r_cls <= n_cls; r_cls2 <= n_cls2;
        r_res <= n_res;
    end

    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        17'(r_used + r_spare) == SPAN17)
        else $error("used plus free bytes drifted from heap size");
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_ready)
        else $error("ready during clearing pass");
    a_ins_sets_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IN3) |=> (r_map != '0))
        else $error("list push left bitmap empty");
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_res.status != sfha_pkg::ST_DONE) |-> (r_res.addr == '0))
        else $error("failed request carries an address");
endmodule
`default_nettype wire

>>> hdl/segregated_fit_heap_allocator_unit.sv
// top level of the segregated-fit heap allocator with stream ports
// Segregated-fit heap allocator over HEAP_BYTES bytes held as 8-byte words in one
// single-port synchronous memory. Each request (allocate or free) is one input
// transfer and yields exactly one result transfer with status, payload offset and
// the running allocated and free byte counters. Requests are handled one at a
// time by a sequencer that does at most one memory access per cycle; the time a
// request takes is set by the chain of dependent header, link and footer reads
// and writes through the single memory port. A request also waits while the
// output register still holds an undrained result. After reset a clearing pass
// over every heap word initializes the heap before the first request is taken.
// HEAP_BYTES must be a power of two. A finished result waits in an output
// register while the next request is taken.
`default_nettype none
module segregated_fit_heap_allocator_unit #(
    parameter int unsigned HEAP_BYTES  = sfha_pkg::HEAP_BYTES_DEF,
    parameter int unsigned CLASS_COUNT = sfha_pkg::CLASS_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // request_size[15:0], payload_addr[31:16]
    input  wire logic        i_s_tuser,   // action: 0 allocate, 1 free
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata    // status[1:0], result_addr[17:2],
                                          // allocated_bytes[34:18], free_bytes[51:35]
);
    localparam int unsigned AW = $clog2(HEAP_BYTES / sfha_pkg::WORD_BYTES);

    sfha_pkg::t_mem_req w_mem;
    sfha_pkg::t_result  w_res;
    logic [31:0] w_rdata;
    logic        w_ready, w_done, w_out_free;
    logic        r_out_valid;
    sfha_pkg::t_result r_out;

    // output slot is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = w_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.spare, r_out.used, r_out.addr, r_out.status};

    sfha_ctrl #(
        .HEAP_BYTES  (HEAP_BYTES),
        .CLASS_COUNT (CLASS_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_s_tvalid && w_ready),
        .i_action   (i_s_tuser),
        .i_size     (i_s_tdata[15:0]),
        .i_addr     (i_s_tdata[31:16]),
        .o_ready    (w_ready),
        .i_out_free (w_out_free),
        .o_done     (w_done),
        .o_res      (w_res),
        .o_mem      (w_mem),
        .i_rdata    (w_rdata)
    );

    sfha_heap_ram #(
        .AW (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // result register toward the output stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end
endmodule
`default_nettype wire
